### design/stack_with_middle_access_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stack with middle access
// Concurrent property wrappers that vanish when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_MIDDLE_ACCESS_MACROS_SVH
`define STACK_WITH_MIDDLE_ACCESS_MACROS_SVH

`ifndef SYNTH
`define SWMID_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define SWMID_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define SWMID_ASSERT(lbl, clk, rst, prop)
`define SWMID_NEVER(lbl, clk, rst, expr)
`endif

`endif

### design/swmid_pkg.sv
// ----------------------------------------------------------------------------
// Stack with middle access package
// Command and status codes, fixed field widths and the cell control group.
// ----------------------------------------------------------------------------
package swmid_pkg;

   localparam int RESULT_W = 32;
   localparam int DEPTH_W  = 7;

   typedef enum logic [1:0] {
      CMD_PUSH     = 2'd0,
      CMD_POP      = 2'd1,
      CMD_READ_MID = 2'd2,
      CMD_DEL_MID  = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic load;
      logic push;
      logic del;
      logic pop;
      logic rd;
   } cell_op_type;

endpackage

### design/swmid_cell.sv
// ----------------------------------------------------------------------------
// Stack cell
// Holds one entry, takes a push or its upper neighbor's entry, and marks
// itself as the entry to be read by the pending beat.
// ----------------------------------------------------------------------------
module swmid_cell #(
   parameter int IDX = 0,
   parameter int CW  = 7,
   parameter int VW  = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  swmid_pkg::cell_op_type op,
   input  logic [CW-1:0]          count,
   input  logic [VW-1:0]          push_data,
   input  logic [VW-1:0]          next_value,
   output logic [VW-1:0]          value,
   output logic [VW-1:0]          read_data
);
   import swmid_pkg::*;

   logic [VW-1:0] value_ff;
   logic [VW-1:0] value_in;
   logic          sel_ff;
   logic          sel_in;
   logic [CW-1:0] mid;
   logic          at_top;
   logic          below_top;
   logic          above_mid;

   assign mid       = count >> 1;
   assign at_top    = (count == CW'(IDX));
   assign below_top = (count == CW'(IDX + 1));
   assign above_mid = (CW'(IDX) >= mid);

   always_comb begin
      value_in = value_ff;
      if (op.push && at_top) begin
         value_in = push_data;
      end else if (op.del && above_mid) begin
         value_in = next_value;
      end
   end

   always_comb begin
      sel_in = sel_ff;
      if (op.load) begin
         sel_in = (op.pop && below_top) || (op.rd && (mid == CW'(IDX)));
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
      end
   end

   assign value     = value_ff;
   assign read_data = sel_ff ? value_ff : '0;

endmodule

### design/stack_with_middle_access.sv
// ----------------------------------------------------------------------------
// Stack with middle access
// Bounded stack of values built as a row of cells, with push, pop, read of
// the middle entry and delete of the middle entry.
// ----------------------------------------------------------------------------
// Each request beat carries a command and a push value; each command gives
// exactly one response beat with the read value, a status and the depth that
// the stack holds after the command. The middle is the entry at bottom index
// count/2; on delete it and every cell above it take their upper neighbor.
// All cells update in the cycle the request is accepted. The selected cell
// is then read and the response register loaded once that register is
// free, so one command per cycle is sustained while the receiver does not
// stall. That rate is set by the cell row, which updates in parallel,
// and by the one read stage between the cells and the response register.
// When the receiver stalls, the response holds, one more command may be
// taken into the read stage, and then req_stall rises until the response
// moves on. Reset empties the stack and the pipeline; the cell contents are
// not cleared and are never read before they are written.
// ----------------------------------------------------------------------------
`include "stack_with_middle_access_macros.svh"

module stack_with_middle_access #(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_command,
   input  logic signed [swmid_pkg::RESULT_W-1:0] req_push_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [swmid_pkg::RESULT_W-1:0] rsp_result_value,
   output logic [1:0]                           rsp_status,
   output logic [swmid_pkg::DEPTH_W-1:0]         rsp_depth_after
);
   import swmid_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [DEPTH_W-1:0] FULL_DEPTH = DEPTH_W'(CAPACITY);

   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;
   logic                   p_valid_ff;
   logic                   p_valid_in;
   status_type             p_status_ff;
   status_type             p_status_in;
   logic [DEPTH_W-1:0]     p_depth_ff;
   logic [DEPTH_W-1:0]     p_depth_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [RESULT_W-1:0]    rsp_result_ff;
   status_type             rsp_status_ff;
   logic [DEPTH_W-1:0]     rsp_depth_ff;

   logic                   accept;
   logic                   advance;
   logic                   empty;
   logic                   full;
   command_type            cmd;
   cell_op_type            op;
   logic [VALUE_WIDTH-1:0] push_data;
   logic [VALUE_WIDTH-1:0] values [CAPACITY];
   logic [VALUE_WIDTH-1:0] reads  [CAPACITY];
   logic [VALUE_WIDTH-1:0] read_or;
   logic [RESULT_W-1:0]    read_result;

   assign cmd     = command_type'(req_command);
   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CW'(CAPACITY));
   assign advance = p_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = p_valid_ff && !advance;
   assign accept  = req_valid && !req_stall;

   generate
      if (VALUE_WIDTH <= RESULT_W) begin : g_push_narrow
         assign push_data   = req_push_value[VALUE_WIDTH-1:0];
         assign read_result = RESULT_W'(read_or);
      end else begin : g_push_wide
         assign push_data   = VALUE_WIDTH'(req_push_value[RESULT_W-1:0]);
         assign read_result = read_or[RESULT_W-1:0];
      end
      if (CW >= DEPTH_W) begin : g_depth_trunc
         assign p_depth_in = count_in[DEPTH_W-1:0];
      end else begin : g_depth_ext
         assign p_depth_in = DEPTH_W'(count_in);
      end
   endgenerate

   always_comb begin
      op          = '0;
      op.load     = accept;
      count_in    = count_ff;
      p_status_in = ST_OK;
      case (cmd)
         CMD_PUSH: begin
            if (full) begin
               p_status_in = ST_FULL;
            end else begin
               op.push  = accept;
               count_in = count_ff + CW'(1);
            end
         end
         CMD_POP: begin
            if (empty) begin
               p_status_in = ST_EMPTY;
            end else begin
               op.pop   = accept;
               count_in = count_ff - CW'(1);
            end
         end
         CMD_READ_MID: begin
            if (empty) begin
               p_status_in = ST_EMPTY;
            end else begin
               op.rd = accept;
            end
         end
         CMD_DEL_MID: begin
            if (empty) begin
               p_status_in = ST_EMPTY;
            end else begin
               op.del   = accept;
               count_in = count_ff - CW'(1);
            end
         end
         default: begin
            p_status_in = ST_OK;
         end
      endcase
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [VALUE_WIDTH-1:0] upper;
         if (gi == CAPACITY - 1) begin : g_last
            assign upper = '0;
         end else begin : g_mid
            assign upper = values[gi + 1];
         end
         swmid_cell #(
            .IDX (gi),
            .CW  (CW),
            .VW  (VALUE_WIDTH)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .op         (op),
            .count      (count_ff),
            .push_data  (push_data),
            .next_value (upper),
            .value      (values[gi]),
            .read_data  (reads[gi])
         );
      end
   endgenerate

   always_comb begin
      read_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_or = read_or | reads[i];
      end
   end

   always_comb begin
      p_valid_in = p_valid_ff;
      if (accept) begin
         p_valid_in = 1'b1;
      end else if (advance) begin
         p_valid_in = 1'b0;
      end
   end

   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p_status_ff <= p_status_in;
         p_depth_ff  <= p_depth_in;
      end
      if (advance) begin
         rsp_result_ff <= read_result;
         rsp_status_ff <= p_status_ff;
         rsp_depth_ff  <= p_depth_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_result_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_depth_after  = rsp_depth_ff;

   `SWMID_NEVER(a_count_range, clock, reset, count_ff > CW'(CAPACITY))
   `SWMID_ASSERT(a_full_depth, clock, reset, (rsp_valid_ff && (rsp_status_ff == ST_FULL)) |-> (rsp_depth_ff == FULL_DEPTH))
   `SWMID_ASSERT(a_empty_zero, clock, reset, (rsp_valid_ff && (rsp_status_ff == ST_EMPTY)) |-> ((rsp_result_ff == '0) && (rsp_depth_ff == '0)))

endmodule
